// ----- hw/rtl/sld_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sld_pkg
// Shared types and constants of the sync/length/checksum frame receiver.
// ---------------------------------------------------------------------------
package sld_pkg;

    localparam int MAX_FRAME_DEF = 32;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 6;
    localparam int STATUS_W      = 2;
    localparam int ROUTE_W       = 2;
    localparam int USER_W        = STATUS_W + ROUTE_W;
    localparam int ADDR_W        = 4;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hAA;
    localparam logic [LEN_W-1:0]  DRIVE_LEN_RST   = 6'd12;
    localparam logic [LEN_W-1:0]  BLADE_LEN_RST   = 6'd7;

    localparam logic [STATUS_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_CHK = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_LEN = 2'd2;

    localparam logic [ROUTE_W-1:0] ROUTE_NONE  = 2'd0;
    localparam logic [ROUTE_W-1:0] ROUTE_DRIVE = 2'd1;
    localparam logic [ROUTE_W-1:0] ROUTE_BLADE = 2'd2;

    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_DRIVE_LEN   = 2'd2;
    localparam logic [1:0] REG_BLADE_LEN   = 2'd3;

    typedef struct packed {
        logic in_fire;
        logic rd_issue;
        logic emit_load;
    } sld_cmd_t;

    typedef struct packed {
        logic frame_good;
        logic out_free;
        logic rd_last;
    } sld_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sync_length_checksum_deframer_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sync_length_checksum_deframer_core
// Receive bytes, find framed packets, check the additive checksum, read out.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel carries one received byte per item in s_tdata[7:0].
//   Bytes are taken one per cycle while a frame is being collected and the output register is free.
//   A frame is two sync bytes, a length byte, that many payload bytes and
//   a checksum byte (mod-256 sum of all earlier frame bytes).
//   A good frame is read out on the m_ channel, one item per stored byte,
//   m_tlast on the final byte; s_tready stays low during readout, in which
//   each byte takes a buffer read step and then an output load step, and the
//   first item is loaded through these steps after the checksum byte is taken.
//   A checksum error or an oversized length gives one item with status set
//   and m_tlast high, valid the cycle after the offending byte.
//   m_tuser[1:0] is status, m_tuser[3:2] is route (1 drive, 2 blade).
//   A stalled m_ side holds the output register and blocks input.
//   Reset returns the block to the sync hunt and restores register defaults.
//   Registers (APB, byte address 4*i): sync_first, sync_second,
//   drive_total_len, blade_total_len.
// ---------------------------------------------------------------------------
module sync_length_checksum_deframer_core import sld_pkg::*; #(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata,   // [7:0] frame_byte
    output logic [USER_W-1:0]      m_tuser,   // [1:0] status, [3:2] route
    output logic                   m_tlast,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [LEN_W-1:0]  drive_len_reg;
    logic [LEN_W-1:0]  blade_len_reg;
    logic              cfg_wr;

    sld_cmd_t cmd;
    sld_sts_t sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            drive_len_reg   <= DRIVE_LEN_RST;
            blade_len_reg   <= BLADE_LEN_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SYNC_FIRST:  sync_first_reg  <= pwdata[BYTE_W-1:0];
                REG_SYNC_SECOND: sync_second_reg <= pwdata[BYTE_W-1:0];
                REG_DRIVE_LEN:   drive_len_reg   <= pwdata[LEN_W-1:0];
                REG_BLADE_LEN:   blade_len_reg   <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SYNC_FIRST:  prdata = 32'(sync_first_reg);
            REG_SYNC_SECOND: prdata = 32'(sync_second_reg);
            REG_DRIVE_LEN:   prdata = 32'(drive_len_reg);
            REG_BLADE_LEN:   prdata = 32'(blade_len_reg);
            default:         prdata = '0;
        endcase
    end

    sld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sld_dp #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .rx_byte     (s_tdata),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .drive_len   (drive_len_reg),
        .blade_len   (blade_len_reg),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    a_no_accept_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output register blocked");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] != STAT_OK)) |-> m_tlast)
        else $error("error item without last");

    a_error_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] != STAT_OK)) |-> (m_tdata == '0 && m_tuser[3:2] == ROUTE_NONE))
        else $error("error item carries data");

endmodule
`default_nettype wire

// ----- hw/rtl/sld_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sld_ctrl
// Sequencer: collect bytes, then read the stored frame out one item at a time.
// ---------------------------------------------------------------------------
module sld_ctrl import sld_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire sld_sts_t sts,
    output sld_cmd_t      cmd
);

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_READ    = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.in_fire   = 1'b0;
        cmd.rd_issue  = 1'b0;
        cmd.emit_load = 1'b0;
        case (state_reg)
            ST_COLLECT: begin
                s_tready    = sts.out_free;
                cmd.in_fire = s_tvalid && sts.out_free;
                if (cmd.in_fire && sts.frame_good) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.rd_last ? ST_COLLECT : ST_READ;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sld_dp.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sld_dp
// Datapath: frame position, running sum, frame buffer and output register.
// ---------------------------------------------------------------------------
module sld_dp import sld_pkg::*; #(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sld_cmd_t          cmd,
    output sld_sts_t               sts,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic [BYTE_W-1:0] sync_first,
    input  wire logic [BYTE_W-1:0] sync_second,
    input  wire logic [LEN_W-1:0]  drive_len,
    input  wire logic [LEN_W-1:0]  blade_len,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [BYTE_W-1:0]      m_tdata,
    output logic [USER_W-1:0]      m_tuser,
    output logic                   m_tlast
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int PW = $clog2(MAX_FRAME + 1);
    localparam int CW = (PW > LEN_W) ? PW : LEN_W;

    logic [BYTE_W-1:0] mem [MAX_FRAME];

    logic [AW-1:0]       pos_reg;
    logic [BYTE_W-1:0]   sum_reg;
    logic [BYTE_W-1:0]   len_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic [PW-1:0]       total_reg;
    logic [ROUTE_W-1:0]  route_reg;
    logic [BYTE_W-1:0]   rd_data_reg;

    logic                m_valid_reg;
    logic [BYTE_W-1:0]   m_byte_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ROUTE_W-1:0]  m_route_reg;
    logic                m_last_reg;

    logic               at_first;
    logic               at_second;
    logic               at_len;
    logic               in_payload;
    logic               at_chk;
    logic               len_big;
    logic               sum_ok;
    logic               err_load;
    logic [PW-1:0]      total_w;
    logic [CW-1:0]      total_c;
    logic [ROUTE_W-1:0] route_w;

    assign at_first   = (pos_reg == AW'(0));
    assign at_second  = (pos_reg == AW'(1));
    assign at_len     = (pos_reg == AW'(2));
    assign in_payload = (9'(pos_reg) <= ({1'b0, len_reg} + 9'd2));
    assign at_chk     = !at_first && !at_second && !at_len && !in_payload;
    assign len_big    = (({1'b0, rx_byte} + 9'd4) > 9'(MAX_FRAME));
    assign sum_ok     = (sum_reg == rx_byte);
    assign total_w    = PW'(pos_reg) + PW'(1);
    assign total_c    = CW'(total_w);

    always_comb begin
        if (total_c == CW'(drive_len)) begin
            route_w = ROUTE_DRIVE;
        end else if (total_c == CW'(blade_len)) begin
            route_w = ROUTE_BLADE;
        end else begin
            route_w = ROUTE_NONE;
        end
    end

    assign err_load = cmd.in_fire && ((at_len && len_big) || (at_chk && !sum_ok));

    assign sts.frame_good = at_chk && sum_ok;
    assign sts.out_free   = !m_valid_reg || m_tready;
    assign sts.rd_last    = ((PW'(rd_idx_reg) + PW'(1)) == total_reg);

    always_ff @(posedge aclk) begin
        if (cmd.in_fire) begin
            mem[pos_reg] <= rx_byte;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            sum_reg <= '0;
            len_reg <= '0;
        end else if (cmd.in_fire) begin
            if (at_first) begin
                if (rx_byte == sync_first) begin
                    sum_reg <= rx_byte;
                    pos_reg <= AW'(1);
                end
            end else if (at_second) begin
                if (rx_byte == sync_second) begin
                    sum_reg <= sum_reg + rx_byte;
                    pos_reg <= pos_reg + AW'(1);
                end else begin
                    sum_reg <= '0;
                    pos_reg <= '0;
                end
            end else if (at_len) begin
                if (len_big) begin
                    sum_reg <= '0;
                    pos_reg <= '0;
                end else begin
                    len_reg <= rx_byte;
                    sum_reg <= sum_reg + rx_byte;
                    pos_reg <= pos_reg + AW'(1);
                end
            end else if (in_payload) begin
                sum_reg <= sum_reg + rx_byte;
                pos_reg <= pos_reg + AW'(1);
            end else begin
                sum_reg <= '0;
                pos_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_fire && at_chk && sum_ok) begin
            total_reg  <= total_w;
            route_reg  <= route_w;
            rd_idx_reg <= '0;
        end else if (cmd.emit_load) begin
            rd_idx_reg <= rd_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (err_load || cmd.emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (err_load) begin
            m_status_reg <= at_len ? STAT_LEN : STAT_CHK;
            m_byte_reg   <= '0;
            m_route_reg  <= ROUTE_NONE;
            m_last_reg   <= 1'b1;
        end else if (cmd.emit_load) begin
            m_status_reg <= STAT_OK;
            m_byte_reg   <= rd_data_reg;
            m_route_reg  <= route_reg;
            m_last_reg   <= sts.rd_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = {m_route_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire
